### src/sapu_pkg.sv
package sapu_pkg;

    typedef enum logic [1:0] {
        KIND_VALUE,
        KIND_SBYTE,
        KIND_SEND,
        KIND_STATUS
    } t_kind;

    typedef enum logic [1:0] {
        CAT_SENSOR,
        CAT_BINARY,
        CAT_EVENT,
        CAT_OTHER
    } t_cat;

    typedef enum logic [2:0] {
        ST_OK,
        ST_UNKNOWN_ID,
        ST_TRUNCATED,
        ST_BAD_VERSION,
        ST_KEY_MISMATCH,
        ST_ENCRYPTED,
        ST_EMPTY
    } t_status;

    localparam logic REG_VERSION = 1'b0;
    localparam logic REG_KEY     = 1'b1;

    localparam logic [2:0] VERSION_RESET = 3'd2;
    localparam int         ENC_BIT       = 0;

    localparam logic [7:0] ID_BIN_LO = 8'h15;
    localparam logic [7:0] ID_BIN_HI = 8'h2D;
    localparam logic [7:0] ID_TEXT   = 8'h53;
    localparam logic [7:0] ID_RAW    = 8'h54;

    typedef struct packed {
        logic [2:0] version;
        logic       key;
    } t_cfg;

    typedef struct packed {
        logic       found;
        t_cat       cat;
        logic [2:0] len;
        logic       sgn;
        logic [1:0] negexp;
    } t_obj_info;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         id;
        t_cat               cat;
        logic signed [32:0] raw;
        logic signed [2:0]  dexp;
        logic [4:0]         idx;
        logic [7:0]         sbyte;
        logic [7:0]         slen;
        t_status            status;
        logic               last;
    } t_result;

    function automatic t_obj_info obj_row(input t_cat cat, input logic [2:0] len,
                                          input logic sgn, input logic [1:0] negexp);
        t_obj_info r;
        r.found  = 1'b1;
        r.cat    = cat;
        r.len    = len;
        r.sgn    = sgn;
        r.negexp = negexp;
        return r;
    endfunction

    // A length of zero marks a length-prefixed string object.
    function automatic t_obj_info obj_lookup(input logic [7:0] id);
        t_obj_info r;
        r = '0;
        if (id >= ID_BIN_LO && id <= ID_BIN_HI) begin
            r = obj_row(CAT_BINARY, 3'd1, 1'b0, 2'd0);
        end else begin
            case (id)
                8'h00: r = obj_row(CAT_OTHER, 3'd1, 1'b0, 2'd0);
                8'h01, 8'h09, 8'h2E, 8'h2F, 8'h46:
                    r = obj_row(CAT_SENSOR, 3'd1, 1'b0, 2'd0);
                8'h02, 8'h08:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b1, 2'd2);
                8'h03, 8'h06, 8'h07, 8'h14, 8'h44:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b0, 2'd2);
                8'h04, 8'h05, 8'h0B:
                    r = obj_row(CAT_SENSOR, 3'd3, 1'b0, 2'd2);
                8'h0A, 8'h42, 8'h4B:
                    r = obj_row(CAT_SENSOR, 3'd3, 1'b0, 2'd3);
                8'h0C, 8'h43, 8'h49, 8'h51, 8'h52:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b0, 2'd3);
                8'h0D, 8'h0E, 8'h12, 8'h13, 8'h3D, 8'h40, 8'h48:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b0, 2'd0);
                8'h3E, 8'h50:
                    r = obj_row(CAT_SENSOR, 3'd4, 1'b0, 2'd0);
                8'h3F, 8'h45:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b1, 2'd1);
                8'h41, 8'h47, 8'h4A:
                    r = obj_row(CAT_SENSOR, 3'd2, 1'b0, 2'd1);
                8'h4C, 8'h4D, 8'h4E, 8'h4F:
                    r = obj_row(CAT_SENSOR, 3'd4, 1'b0, 2'd3);
                8'h0F, 8'h10, 8'h11:
                    r = obj_row(CAT_BINARY, 3'd1, 1'b0, 2'd0);
                8'h3A: r = obj_row(CAT_EVENT, 3'd1, 1'b0, 2'd0);
                8'h3C: r = obj_row(CAT_EVENT, 3'd2, 1'b0, 2'd0);
                ID_TEXT, ID_RAW:
                    r = obj_row(CAT_OTHER, 3'd0, 1'b0, 2'd0);
                8'hF0: r = obj_row(CAT_OTHER, 3'd2, 1'b0, 2'd0);
                8'hF1: r = obj_row(CAT_OTHER, 3'd4, 1'b0, 2'd0);
                8'hF2: r = obj_row(CAT_OTHER, 3'd3, 1'b0, 2'd0);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

### src/sensor_adv_object_parser_unit.sv
// Parses one service-data byte per clock cycle into object, string and status
// transfers. A result is written into a four-entry output queue when its byte
// is taken. A byte yields at most two results (an object completed or a string
// byte stored on the packet's last byte, plus the packet status); the queue
// drains one result per cycle while the output is not stalled, and input stalls
// while fewer than two entries are free. Two-result bytes close a packet and
// cannot follow one another, so the queue never fills while the output side
// takes a result every cycle: the rate is one byte per cycle, and the input
// stalls only after the output side has stalled. Per-id instance counts sit in
// a 256-entry memory with a registered read; the entry is read while the id
// byte is taken and written back when the object ends. Per-entry valid flags
// are cleared at each packet start, so no clearing pass is needed after reset.
module sensor_adv_object_parser_unit
    import sapu_pkg::*;
#(
    parameter int STRING_CAPACITY = 16,
    parameter int INDEX_WIDTH     = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_packet_first,
    input  logic               i_packet_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_result_kind,
    output logic [7:0]         o_object_id,
    output logic [1:0]         o_category,
    output logic signed [32:0] o_raw_value,
    output logic signed [2:0]  o_decimal_exponent,
    output logic [4:0]         o_instance_index,
    output logic [7:0]         o_string_byte,
    output logic [7:0]         o_string_length,
    output logic [2:0]         o_status_code,
    output logic               o_last_of_packet
);

    t_cfg       r_cfg;
    logic       accept;
    logic       cfg_wr;
    logic [1:0] push_cnt;
    t_result    res0;
    t_result    res1;
    t_result    res_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version <= VERSION_RESET;
            r_cfg.key     <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_VERSION: r_cfg.version <= pwdata[2:0];
                REG_KEY:     r_cfg.key     <= pwdata[0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VERSION: prdata = {29'd0, r_cfg.version};
            REG_KEY:     prdata = {31'd0, r_cfg.key};
            default:     prdata = 32'd0;
        endcase
    end

    sapu_parser #(
        .STRING_CAPACITY (STRING_CAPACITY),
        .INDEX_WIDTH     (INDEX_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first     (i_packet_first),
        .i_last      (i_packet_last),
        .o_push_cnt  (push_cnt),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    sapu_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_full     (o_in_stall),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (res_out)
    );

    assign o_result_kind      = res_out.kind;
    assign o_object_id        = res_out.id;
    assign o_category         = res_out.cat;
    assign o_raw_value        = res_out.raw;
    assign o_decimal_exponent = res_out.dexp;
    assign o_instance_index   = res_out.idx;
    assign o_string_byte      = res_out.sbyte;
    assign o_string_length    = res_out.slen;
    assign o_status_code      = res_out.status;
    assign o_last_of_packet   = res_out.last;

endmodule

### src/sapu_ram.sv
module sapu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/sapu_parser.sv
module sapu_parser
    import sapu_pkg::*;
#(
    parameter int STRING_CAPACITY = 16,
    parameter int INDEX_WIDTH     = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    input  logic       i_last,
    output logic [1:0] o_push_cnt,
    output t_result    o_res0,
    output t_result    o_res1
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_VALUE,
        PH_SLEN,
        PH_SBODY
    } t_phase;

    localparam logic [INDEX_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [7:0]             CAP     = 8'(STRING_CAPACITY);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_rem, n_rem;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_pos, n_pos;
    logic        r_abort, n_abort;
    logic [255:0] r_vld;
    logic        r_rd_vld;

    logic [INDEX_WIDTH-1:0] rd_data;
    logic [INDEX_WIDTH-1:0] cnt;
    logic [INDEX_WIDTH-1:0] cnt_inc;
    logic [7:0]  cnt_wide;
    logic [7:0]  rd_addr;
    logic        bump;
    logic        clr;
    logic        tail;
    logic        obj_emit;
    logic        stat_emit;
    t_status     stat_code;
    logic [7:0]  stat_id;
    t_result     obj_res;
    t_result     stat_res;
    t_obj_info   info_b;
    t_obj_info   info_c;
    t_cat        cat_eff;
    logic [2:0]  len_eff;
    logic        sgn_eff;
    logic [31:0] acc_upd;
    logic [32:0] ext;
    logic [7:0]  rem_dec;
    logic [7:0]  pos_new;
    logic        stored;

    sapu_ram #(
        .WIDTH (INDEX_WIDTH),
        .DEPTH (256)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (bump),
        .i_waddr (r_id),
        .i_wdata (cnt_inc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_addr  = (i_accept && r_phase == PH_ID) ? i_data_byte : r_id;
    assign cnt      = r_rd_vld ? rd_data : '0;
    assign cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    assign cnt_wide = 8'(cnt);
    assign info_b   = obj_lookup(i_data_byte);
    assign info_c   = obj_lookup(r_id);
    assign rem_dec  = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;
    assign acc_upd  = r_acc | ({24'b0, i_data_byte} << {r_pos[1:0], 3'b000});
    assign stored   = r_pos < CAP;
    assign pos_new  = stored ? r_pos + 8'd1 : r_pos;

    always_comb begin
        cat_eff = info_c.found ? info_c.cat : CAT_OTHER;
        len_eff = info_c.found ? info_c.len : 3'd4;
        sgn_eff = info_c.found & info_c.sgn;
        case (len_eff)
            3'd1:    ext = {{25{sgn_eff & acc_upd[7]}}, acc_upd[7:0]};
            3'd2:    ext = {{17{sgn_eff & acc_upd[15]}}, acc_upd[15:0]};
            3'd3:    ext = {{9{sgn_eff & acc_upd[23]}}, acc_upd[23:0]};
            default: ext = {sgn_eff & acc_upd[31], acc_upd};
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_abort   = r_abort;
        bump      = 1'b0;
        clr       = 1'b0;
        tail      = 1'b0;
        obj_emit  = 1'b0;
        stat_emit = 1'b0;
        stat_code = ST_OK;
        stat_id   = 8'd0;
        obj_res   = '0;
        obj_res.id  = r_id;
        obj_res.idx = cnt_wide[4:0];

        if (i_accept) begin
            if (i_first) begin
                clr     = 1'b1;
                n_id    = 8'd0;
                n_rem   = 8'd0;
                n_acc   = 32'd0;
                n_pos   = 8'd0;
                n_abort = 1'b0;
                n_phase = PH_IDLE;
                if (i_data_byte[7:5] != i_cfg.version) begin
                    stat_emit = 1'b1;
                    stat_code = ST_BAD_VERSION;
                end else if (i_data_byte[ENC_BIT]) begin
                    stat_emit = 1'b1;
                    stat_code = ST_ENCRYPTED;
                end else if (i_cfg.key) begin
                    stat_emit = 1'b1;
                    stat_code = ST_KEY_MISMATCH;
                end else if (i_last) begin
                    stat_emit = 1'b1;
                    stat_code = ST_OK;
                end else begin
                    n_phase = PH_ID;
                end
                if (stat_emit && !i_last) begin
                    n_abort = 1'b1;
                end
            end else if (r_phase == PH_IDLE) begin
                if (r_abort) begin
                    if (i_last) begin
                        n_abort = 1'b0;
                    end
                end else if (i_last) begin
                    stat_emit = 1'b1;
                    stat_code = ST_EMPTY;
                end
            end else begin
                tail = 1'b1;
                case (r_phase)
                    PH_ID: begin
                        // An id arriving as the packet's last byte is dropped.
                        if (!i_last) begin
                            if (!info_b.found) begin
                                stat_emit = 1'b1;
                                stat_code = ST_UNKNOWN_ID;
                                stat_id   = i_data_byte;
                                n_phase   = PH_IDLE;
                                n_abort   = 1'b1;
                                tail      = 1'b0;
                            end else begin
                                n_id    = i_data_byte;
                                n_acc   = 32'd0;
                                n_pos   = 8'd0;
                                n_rem   = {5'b0, info_b.len};
                                n_phase = (info_b.len == 3'd0) ? PH_SLEN : PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        n_acc = acc_upd;
                        n_pos = r_pos + 8'd1;
                        n_rem = rem_dec;
                        if (rem_dec == 8'd0) begin
                            obj_emit    = 1'b1;
                            bump        = 1'b1;
                            n_phase     = PH_ID;
                            obj_res.kind = KIND_VALUE;
                            obj_res.cat  = cat_eff;
                            obj_res.raw  = (cat_eff == CAT_BINARY) ? {32'd0, |ext} : ext;
                            obj_res.dexp = (cat_eff == CAT_SENSOR) ?
                                           3'(3'd0 - {1'b0, info_c.negexp}) : 3'd0;
                        end
                    end
                    PH_SLEN: begin
                        n_rem = i_data_byte;
                        n_pos = 8'd0;
                        if (i_data_byte == 8'd0) begin
                            obj_emit     = 1'b1;
                            bump         = 1'b1;
                            n_phase      = PH_ID;
                            obj_res.kind = KIND_SEND;
                            obj_res.cat  = CAT_OTHER;
                        end else begin
                            n_phase = PH_SBODY;
                        end
                    end
                    PH_SBODY: begin
                        n_pos = pos_new;
                        n_rem = rem_dec;
                        obj_res.cat = CAT_OTHER;
                        if (rem_dec == 8'd0) begin
                            obj_emit      = 1'b1;
                            bump          = 1'b1;
                            n_phase       = PH_ID;
                            obj_res.kind  = KIND_SEND;
                            obj_res.sbyte = stored ? i_data_byte : 8'd0;
                            obj_res.slen  = pos_new;
                        end else if (stored) begin
                            obj_emit      = 1'b1;
                            obj_res.kind  = KIND_SBYTE;
                            obj_res.sbyte = i_data_byte;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (tail && i_last) begin
                    stat_emit = 1'b1;
                    if (n_phase == PH_ID) begin
                        stat_code = ST_OK;
                    end else begin
                        stat_code = ST_TRUNCATED;
                        stat_id   = n_id;
                    end
                    n_phase = PH_IDLE;
                    n_abort = 1'b0;
                end
            end
        end
    end

    always_comb begin
        stat_res        = '0;
        stat_res.kind   = KIND_STATUS;
        stat_res.id     = stat_id;
        stat_res.status = stat_code;
        stat_res.last   = 1'b1;
        o_res1          = stat_res;
        if (obj_emit) begin
            o_res0     = obj_res;
            o_push_cnt = stat_emit ? 2'd2 : 2'd1;
        end else begin
            o_res0     = stat_res;
            o_push_cnt = stat_emit ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_id     <= 8'd0;
            r_rem    <= 8'd0;
            r_acc    <= 32'd0;
            r_pos    <= 8'd0;
            r_abort  <= 1'b0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_id     <= n_id;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_abort  <= n_abort;
            r_rd_vld <= r_vld[rd_addr];
            if (clr) begin
                r_vld <= '0;
            end else if (bump) begin
                r_vld[r_id] <= 1'b1;
            end
        end
    end

endmodule

### src/sapu_outq.sv
module sapu_outq
    import sapu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_result        r_q [DEPTH];
    logic [AW-1:0]  r_head;
    logic [AW-1:0]  r_tail;
    logic [AW:0]    r_cnt;
    logic           pop;
    logic [AW-1:0]  tail_nx;

    assign pop     = (r_cnt != '0) && !i_stall;
    assign tail_nx = r_tail + 1'b1;
    assign o_full  = r_cnt > (AW+1)'(DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_q[r_tail] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_q[tail_nx] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + AW'(i_push_cnt);
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
        end
    end

endmodule

### src/sapu_chk.sv
module sapu_chk
    import sapu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_result_kind,
    input logic signed [32:0] o_raw_value,
    input logic [7:0]         o_string_length,
    input logic [2:0]         o_status_code,
    input logic               o_last_of_packet
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_packet |-> o_result_kind == KIND_STATUS)
        else $error("packet end flag on a non-status transfer");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_STATUS |-> o_last_of_packet)
        else $error("status transfer without packet end flag");

    a_fields_by_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_VALUE |->
            o_string_length == 8'd0 && o_status_code == 3'd0)
        else $error("object transfer carries string or status fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_raw_value))
        else $error("stalled transfer changed");

endmodule

bind sensor_adv_object_parser_unit sapu_chk u_sapu_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_kind    (o_result_kind),
    .o_raw_value      (o_raw_value),
    .o_string_length  (o_string_length),
    .o_status_code    (o_status_code),
    .o_last_of_packet (o_last_of_packet)
);
